/* design/assert_macros.svh */
// Assertion helper macros shared by the receiver RTL.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted (active low).
`define CRC8FR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define CRC8FR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/crc8fr_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the frame receiver.
// Depends on nothing.
package crc8fr_pkg;

    localparam int MAX_PAYLOAD_DEF = 12;
    localparam int NUM_REPORTED    = 5;   // payload bytes 0..4 are reported

    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'hAA;
    localparam logic [7:0] CRC_POLY   = 8'h8C;

    typedef enum logic [1:0] {
        ST_GOOD      = 2'd0,
        ST_CHECK_ERR = 2'd1,
        ST_BAD_LEN   = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic signed [15:0] first_word;
        logic signed [15:0] second_word;
        logic        [7:0]  flag_byte;
        logic        [7:0]  payload_length;
    } t_result;

    // Reflected CRC-8, one byte, bits taken LSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

    // Check value after the two header bytes.
    localparam logic [7:0] HDR_CRC = crc8_byte(crc8_byte(8'h00, HDR_FIRST), HDR_SECOND);

endpackage

/* design/crc8fr_if.sv */
// Valid/ready channel interfaces for received bytes and frame results.
// Depends on nothing.
interface crc8fr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crc8fr_res_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [15:0] first_word;
    logic signed [15:0] second_word;
    logic        [7:0]  flag_byte;
    logic        [7:0]  payload_length;

    modport source (output valid, output status, output first_word, output second_word,
                    output flag_byte, output payload_length, input ready);
    modport sink   (input valid, input status, input first_word, input second_word,
                    input flag_byte, input payload_length, output ready);
endinterface

/* design/crc8fr_core.sv */
// Deframing state machine with CRC check, payload store and result register.
// Depends on crc8fr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module crc8fr_core #(
    parameter int MAX_PAYLOAD = crc8fr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    output logic                o_take,
    output logic                o_res_valid,
    output crc8fr_pkg::t_result o_res,
    input  logic                i_res_ready
);
    import crc8fr_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK,
        PH_TRAILER
    } t_phase;

    logic             r_hunting, n_hunting;
    logic [7:0]       r_prev, n_prev;
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_frame_len, n_frame_len;
    logic [7:0]       r_crc, n_crc;
    logic             r_trailer, n_trailer;
    logic [7:0]       r_store [NUM_REPORTED];
    logic [7:0]       n_store [NUM_REPORTED];
    logic             r_res_valid;
    t_result          r_res, n_res;
    logic             emit;
    logic             advance;
    logic [CNT_W-1:0] count_inc;

    assign advance   = i_valid && (!r_res_valid || i_res_ready);
    assign o_take    = advance;
    assign count_inc = r_count + 1'b1;

    always_comb begin
        n_hunting   = r_hunting;
        n_prev      = r_prev;
        n_phase     = r_phase;
        n_count     = r_count;
        n_frame_len = r_frame_len;
        n_crc       = r_crc;
        n_trailer   = r_trailer;
        n_store     = r_store;
        emit        = 1'b0;
        n_res       = '{status: ST_GOOD, first_word: '0, second_word: '0,
                        flag_byte: '0, payload_length: '0};

        if (r_hunting) begin
            if (i_byte == HDR_SECOND) begin
                if (r_prev == HDR_FIRST) begin
                    n_hunting = 1'b0;
                    n_phase   = PH_LENGTH;
                    n_count   = '0;
                    n_trailer = 1'b0;
                    n_crc     = HDR_CRC;
                end
            end else begin
                n_prev = i_byte;
            end
        end else begin
            case (r_phase)
                PH_LENGTH: begin
                    if (i_byte == 8'd0 || i_byte > 8'(MAX_PAYLOAD)) begin
                        emit                 = 1'b1;
                        n_res.status         = ST_BAD_LEN;
                        n_res.payload_length = i_byte;
                    end else begin
                        n_frame_len = CNT_W'(i_byte);
                        n_count     = '0;
                        n_crc       = crc8_byte(r_crc, i_byte);
                        n_phase     = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    for (int i = 0; i < NUM_REPORTED; i++) begin
                        if (r_count == CNT_W'(i)) begin
                            n_store[i] = i_byte;
                        end
                    end
                    n_crc   = crc8_byte(r_crc, i_byte);
                    n_count = count_inc;
                    if (count_inc >= r_frame_len) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    if (i_byte != r_crc) begin
                        emit                 = 1'b1;
                        n_res.status         = ST_CHECK_ERR;
                        n_res.payload_length = 8'(r_frame_len);
                    end else begin
                        n_trailer = 1'b0;
                        n_phase   = PH_TRAILER;
                    end
                end
                default: begin
                    if (!r_trailer) begin
                        n_trailer = 1'b1;
                    end else begin
                        emit                 = 1'b1;
                        n_res.status         = ST_GOOD;
                        n_res.first_word     = {r_store[1], r_store[0]};
                        n_res.second_word    = {r_store[3], r_store[2]};
                        n_res.flag_byte      = r_store[4];
                        n_res.payload_length = 8'(r_frame_len);
                    end
                end
            endcase
            // every result ends the frame: back to hunting
            if (emit) begin
                n_hunting   = 1'b1;
                n_prev      = '0;
                n_phase     = PH_LENGTH;
                n_count     = '0;
                n_frame_len = '0;
                n_crc       = '0;
                n_trailer   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting   <= 1'b1;
            r_prev      <= '0;
            r_phase     <= PH_LENGTH;
            r_count     <= '0;
            r_frame_len <= '0;
            r_crc       <= '0;
            r_trailer   <= 1'b0;
            for (int i = 0; i < NUM_REPORTED; i++) begin
                r_store[i] <= '0;
            end
            r_res_valid <= 1'b0;
        end else begin
            if (advance && emit) begin
                r_res_valid <= 1'b1;
                r_res       <= n_res;
            end else if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (advance) begin
                r_hunting   <= n_hunting;
                r_prev      <= n_prev;
                r_phase     <= n_phase;
                r_count     <= n_count;
                r_frame_len <= n_frame_len;
                r_crc       <= n_crc;
                r_trailer   <= n_trailer;
                r_store     <= n_store;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `CRC8FR_ASSERT(a_res_from_byte, i_clk, i_rst_n, $rose(r_res_valid) |-> $past(advance), "result appeared without a byte transfer")
    `CRC8FR_ASSERT(a_hunt_phase, i_clk, i_rst_n, r_hunting |-> (r_phase == PH_LENGTH), "hunting outside length phase")
    `CRC8FR_ASSERT(a_count_bound, i_clk, i_rst_n, (r_phase == PH_PAYLOAD) |-> (r_count < r_frame_len), "payload count overran frame length")
    `CRC8FR_ASSERT(a_err_no_data, i_clk, i_rst_n, (r_res_valid && r_res.status != ST_GOOD) |-> (r_res.first_word == 16'sd0 && r_res.second_word == 16'sd0 && r_res.flag_byte == 8'd0), "error result carries payload data")

endmodule

/* design/crc8_frame_receiver.sv */
// Top level of the framed serial receiver: input register and core hookup.
// Depends on crc8fr_pkg, crc8fr_if and crc8fr_core.
//
// Takes one received byte per transfer on i_rx and hunts for the header
// 0x55 0xAA, then reads a length byte (1..MAX_PAYLOAD), that many payload
// bytes, a reflected CRC-8 check byte (poly 0x8C, init 0, over header,
// length and payload) and two unchecked trailer bytes. One result per
// frame leaves on o_res: status 0 good (words from payload bytes 0..3,
// little endian, flag from byte 4), 1 check mismatch, 2 bad length; an
// error result carries zero data and the receiver resynchronises at once.
// Rate: one byte per clock while results are taken. A byte is held in
// the input register, then folded into the state machine, whose CRC
// update is a combinational XOR network; the result enters the output
// register as the byte ending the frame leaves the input register. The
// input side stalls only while the output register holds a result that
// is not taken and a further byte is waiting. Payload bytes that a
// short frame does not write keep the contents of earlier frames.

module crc8_frame_receiver #(
    parameter int MAX_PAYLOAD = crc8fr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    crc8fr_rx_if.sink    i_rx,
    crc8fr_res_if.source o_res
);
    import crc8fr_pkg::*;

    // input register: one byte waiting for the state machine
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       core_take;
    logic       res_valid;
    t_result    res;

    // free, or the held byte moves on this cycle
    assign i_rx.ready = !r_in_valid || core_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_rx.rx_byte;
            end else if (core_take) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    crc8fr_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_byte      (r_in_byte),
        .o_take      (core_take),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (o_res.ready)
    );

    // result register lives in the core; map it onto the channel
    assign o_res.valid          = res_valid;
    assign o_res.status         = res.status;
    assign o_res.first_word     = res.first_word;
    assign o_res.second_word    = res.second_word;
    assign o_res.flag_byte      = res.flag_byte;
    assign o_res.payload_length = res.payload_length;

endmodule
